// ===== rtl/dpd_pkg.sv =====
package dpd_pkg;

    // framing bytes
    localparam logic [7:0] CH_ACK    = 8'h2B;  // '+'
    localparam logic [7:0] CH_OPEN   = 8'h24;  // '$'
    localparam logic [7:0] CH_CLOSE  = 8'h23;  // '#'
    localparam logic [7:0] CH_ESCAPE = 8'h7D;  // '}'
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam logic ACK_MODE_RESET = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_NAK     = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_ACK  = 2'd1,
        REPLY_NAK  = 2'd2
    } t_reply;

    // ascii hex digit to nibble, anything else reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== rtl/dpd_if.sv =====
// received byte channel
interface dpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface dpd_res_if;
    logic            valid;
    logic            ready;
    dpd_pkg::t_kind  kind;
    logic [7:0]      payload_byte;
    dpd_pkg::t_reply reply;

    modport source (output valid, output kind, output payload_byte, output reply, input ready);
    modport sink   (input valid, input kind, input payload_byte, input reply, output ready);
endinterface

// configuration write channel, ack_mode only
interface dpd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/debug_packet_deframer_core.sv =====
// channel   dir   payload                          meaning
// i_rx      in    rx_byte[7:0]                     one received link byte per word
// o_res     out   kind[1:0] payload_byte[7:0]      payload byte, accept, nak or error
//                 reply[1:0]                       byte to send back (none, '+', '-')
// i_cfg     in    data                             ack_mode, 1 = ack/nak per packet
//
// one word per cycle sustained while the result channel is ready; a byte that makes a
// result passes from the input register into the result register
// synchronous active-low reset: parser waits for '$', sum cleared, ack_mode set to 1
// a stalled result holds the parse stage only when that byte makes a result of its
// own; bytes that make no result drain past a full result register
// config port is always ready
module debug_packet_deframer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dpd_rx_if.sink        i_rx,
    dpd_res_if.source     o_res,
    dpd_cfg_if.sink       i_cfg
);
    import dpd_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_DATA = 3'd1,
        PH_ESC  = 3'd2,
        PH_CK0  = 3'd3,
        PH_CK1  = 3'd4
    } t_phase;

    // control state
    t_phase     r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [3:0] r_digit, n_digit;
    logic       r_ack_mode;
    logic       r_in_vld;
    logic       r_out_vld;

    // payload registers
    logic [7:0] r_in_byte;
    t_kind      r_kind, n_kind;
    logic [7:0] r_pbyte, n_pbyte;
    t_reply     r_reply, n_reply;

    logic       w_has_res;
    logic       w_adv;
    logic [7:0] w_sum_add;
    logic [7:0] w_got;

    assign w_sum_add = r_sum + r_in_byte;
    assign w_got     = {r_digit, hex_value(r_in_byte)};

    // parse logic for the byte in the input register
    always_comb begin
        n_phase   = r_phase;
        n_sum     = r_sum;
        n_digit   = r_digit;
        w_has_res = 1'b0;
        n_kind    = KIND_PAYLOAD;
        n_pbyte   = 8'h00;
        n_reply   = REPLY_NONE;
        unique case (r_phase)
            PH_DATA: begin
                if (r_in_byte == CH_CLOSE) begin
                    n_phase = PH_CK0;
                end else begin
                    n_sum = w_sum_add;
                    if (r_in_byte == CH_ESCAPE) begin
                        n_phase = PH_ESC;
                    end else begin
                        w_has_res = 1'b1;
                        n_pbyte   = r_in_byte;
                    end
                end
            end
            PH_ESC: begin
                // escaped byte is taken xored with 0x20, even '#'
                n_sum     = w_sum_add;
                n_phase   = PH_DATA;
                w_has_res = 1'b1;
                n_pbyte   = r_in_byte ^ ESC_XOR;
            end
            PH_CK0: begin
                n_digit = hex_value(r_in_byte);
                n_phase = PH_CK1;
            end
            PH_CK1: begin
                n_phase   = PH_WAIT;
                w_has_res = 1'b1;
                if (w_got == r_sum) begin
                    n_kind  = KIND_ACCEPT;
                    n_reply = r_ack_mode ? REPLY_ACK : REPLY_NONE;
                end else if (r_ack_mode) begin
                    n_kind  = KIND_NAK;
                    n_reply = REPLY_NAK;
                end else begin
                    n_kind  = KIND_ERROR;
                end
            end
            default: begin
                // waiting for '$'; stray acks are dropped
                n_phase = PH_WAIT;
                if (r_in_byte == CH_OPEN) begin
                    n_sum   = 8'h00;
                    n_phase = PH_DATA;
                end else if (r_in_byte != CH_ACK) begin
                    w_has_res = 1'b1;
                    n_kind    = KIND_ERROR;
                end
            end
        endcase
    end

    // parse stage moves unless its result would overwrite a waiting one
    assign w_adv      = r_in_vld && (!w_has_res || !r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || w_adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_sum      <= 8'h00;
            r_digit    <= 4'h0;
            r_ack_mode <= ACK_MODE_RESET;
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_ack_mode <= i_cfg.data;
            end

            if (i_rx.valid && i_rx.ready) begin
                r_in_vld  <= 1'b1;
                r_in_byte <= i_rx.rx_byte;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end

            if (w_adv) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_digit <= n_digit;
            end

            if (w_adv && w_has_res) begin
                r_out_vld <= 1'b1;
                r_kind    <= n_kind;
                r_pbyte   <= n_pbyte;
                r_reply   <= n_reply;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.kind         = r_kind;
    assign o_res.payload_byte = r_pbyte;
    assign o_res.reply        = r_reply;

    // a held byte in the parse stage stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("parse stage byte lost while stalled");

    // an escaped byte always makes a payload result
    a_esc_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_phase == PH_ESC) |=> (r_out_vld && r_kind == KIND_PAYLOAD
            && r_phase == PH_DATA))
        else $error("escaped byte produced no payload word");

    // nak results always carry a nak reply, payload and error words none
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_kind == KIND_NAK) == (r_reply == REPLY_NAK))
            && (!(r_kind == KIND_PAYLOAD || r_kind == KIND_ERROR)
                || r_reply == REPLY_NONE))
        else $error("reply code does not fit result kind");

    // first checksum digit moves on to the second without a result
    a_ck0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_phase == PH_CK0) |-> !w_has_res ##1 (r_phase == PH_CK1))
        else $error("first checksum digit mishandled");

endmodule
